/* sv/pq4_lut_squared_l2_accumulator_defines.svh */
// assertion macros for the pq4 squared-l2 accumulator
// used by the top level; expects clk and arst_n in scope
`ifndef PQ4_LUT_SQUARED_L2_ACCUMULATOR_DEFINES_SVH
`define PQ4_LUT_SQUARED_L2_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define PQ4_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pq4 assertion failed");

// next-cycle implication
`define PQ4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pq4 assertion failed");

`endif

/* sv/pq4_pkg.sv */
// types and constants shared by the pq4 squared-l2 accumulator
// no dependencies
package pq4_pkg;

	localparam int unsigned CODE_W  = 4;
	localparam int unsigned VALUE_W = 8;
	localparam int unsigned SQ_W    = 2 * VALUE_W;
	localparam int unsigned SUM_W   = 32;
	localparam int unsigned ENTRIES = 16;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [7:0] NIBBLE_LO_MASK = 8'h0f;
	localparam logic [7:0] NIBBLE_HI_MASK = 8'hf0;
	localparam logic [SUM_W-1:0] SUM_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_TABLE_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TABLE_HIGH = 2'd1;

	typedef logic [ENTRIES-1:0][VALUE_W-1:0] lut_t;
	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [SQ_W-1:0]    sq_t;
	typedef logic [SUM_W-1:0]   sum_t;

	typedef struct packed {
		logic valid;
		logic last;
	} s1_ctrl_t;

endpackage

/* sv/pq4_lut_squared_l2_accumulator.sv */
// Squared-L2 distance over 4-bit product-quantization codes. One code byte
// (two elements) is taken per cycle unless input is stalled; an item passes
// the lane stage, where two lanes look up the table and square the gaps,
// then the merging stage that adds into the saturating 32-bit running sum
// and registers the result. Throughput is one item per cycle when not stalled,
// as the merging stage accumulates each item it takes; an unread result stalls
// input only when a further vector end reaches that stage.
// top level; depends on pq4_pkg, pq4_lane, pq4_accum and the defines header
`include "pq4_lut_squared_l2_accumulator_defines.svh"

module pq4_lut_squared_l2_accumulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [pq4_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pq4_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [7:0]                          code_pair,
	input  logic [7:0]                          query_even,
	input  logic [7:0]                          query_odd,
	input  logic                                vector_end,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [31:0]                         squared_distance
);

	logic [pq4_pkg::CFG_DATA_W-1:0] table_low_q;
	logic [pq4_pkg::CFG_DATA_W-1:0] table_high_q;
	pq4_pkg::lut_t     lut;
	pq4_pkg::s1_ctrl_t ctrl_s1;
	pq4_pkg::sq_t      sq_even_s1;
	pq4_pkg::sq_t      sq_odd_s1;
	pq4_pkg::code_t    code_even;
	pq4_pkg::code_t    code_odd;
	logic              take;
	logic              load;
	logic [7:0]        hi_bits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_low_q  <= '0;
			table_high_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pq4_pkg::REG_TABLE_LOW:  table_low_q  <= cfg_data;
				pq4_pkg::REG_TABLE_HIGH: table_high_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		lut = {table_high_q, table_low_q};
		hi_bits = code_pair & pq4_pkg::NIBBLE_HI_MASK;
		code_even = pq4_pkg::code_t'(code_pair & pq4_pkg::NIBBLE_LO_MASK);
		code_odd  = hi_bits[7:4];
		in_ready = !ctrl_s1.valid || take;
		load = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= load || (ctrl_s1.valid && !take);
			if (load) begin
				ctrl_s1.last <= vector_end;
			end
		end
	end

	pq4_lane u_lane_even (
		.clk       (clk),
		.load      (load),
		.code      (code_even),
		.query     (query_even),
		.lut       (lut),
		.square_s1 (sq_even_s1)
	);

	pq4_lane u_lane_odd (
		.clk       (clk),
		.load      (load),
		.code      (code_odd),
		.query     (query_odd),
		.lut       (lut),
		.square_s1 (sq_odd_s1)
	);

	pq4_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl_s1          (ctrl_s1),
		.sq_even_s1       (sq_even_s1),
		.sq_odd_s1        (sq_odd_s1),
		.out_ready        (out_ready),
		.take             (take),
		.out_valid        (out_valid),
		.squared_distance (squared_distance)
	);

	// a vector end waiting behind an unread result holds off input
	`PQ4_ASSERT_IMPL(a_stall_blocks_input, ctrl_s1.valid && ctrl_s1.last && out_valid && !out_ready, !in_ready)
	// a transferred vector end reaches the lane stage as last
	`PQ4_ASSERT_NEXT(a_end_enters_s1, load && vector_end, ctrl_s1.valid && ctrl_s1.last)
	// merging a vector end raises the result
	`PQ4_ASSERT_NEXT(a_end_gives_result, take && ctrl_s1.last, out_valid)
	// a new result only follows a merged vector end
	`PQ4_ASSERT_IMPL(a_result_has_cause, $rose(out_valid), $past(take && ctrl_s1.last))

endmodule

/* sv/pq4_lane.sv */
// one element lane: table lookup, absolute difference and square
// depends on pq4_pkg
module pq4_lane (
	input  logic           clk,
	input  logic           load,
	input  pq4_pkg::code_t  code,
	input  pq4_pkg::value_t query,
	input  pq4_pkg::lut_t   lut,
	output pq4_pkg::sq_t    square_s1
);

	pq4_pkg::value_t entry;
	pq4_pkg::value_t gap;

	always_comb begin
		entry = lut[code];
		gap   = (query >= entry) ? (query - entry) : (entry - query);
	end

	always_ff @(posedge clk) begin
		if (load) begin
			square_s1 <= {{pq4_pkg::VALUE_W{1'b0}}, gap} * {{pq4_pkg::VALUE_W{1'b0}}, gap};
		end
	end

endmodule

/* sv/pq4_accum.sv */
// merging stage: adds both lane squares into the running sum with saturation
// and holds the result register; depends on pq4_pkg
module pq4_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  pq4_pkg::s1_ctrl_t ctrl_s1,
	input  pq4_pkg::sq_t      sq_even_s1,
	input  pq4_pkg::sq_t      sq_odd_s1,
	input  logic              out_ready,
	output logic              take,
	output logic              out_valid,
	output pq4_pkg::sum_t     squared_distance
);

	localparam int unsigned TOT_W = pq4_pkg::SUM_W + 2;

	pq4_pkg::sum_t     running_q;
	logic [TOT_W-1:0]  total;
	pq4_pkg::sum_t     sat_sum;
	logic              out_free;

	always_comb begin
		total = TOT_W'(running_q) + TOT_W'(sq_even_s1) + TOT_W'(sq_odd_s1);
		sat_sum = (|total[TOT_W-1:pq4_pkg::SUM_W]) ? pq4_pkg::SUM_MAX
			: total[pq4_pkg::SUM_W-1:0];
		out_free = !out_valid || out_ready;
		take = ctrl_s1.valid && (!ctrl_s1.last || out_free);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (take) begin
				if (ctrl_s1.last) begin
					running_q <= '0;
					out_valid <= 1'b1;
				end else begin
					running_q <= sat_sum;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctrl_s1.last) begin
			squared_distance <= sat_sum;
		end
	end

endmodule

/* test/pq4_l2_distance_checker.sv */
// scoreboard for the pq4 squared-l2 accumulator: mirrors the lookup table and the
// running sum from observed transfers and compares every emitted distance
// depends on pq4_pkg
module pq4_l2_distance_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pq4_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pq4_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [7:0]                    code_pair,
	input  logic [7:0]                    query_even,
	input  logic [7:0]                    query_odd,
	input  logic                          vector_end,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [31:0]                   squared_distance,
	output int unsigned                   failures,
	output int unsigned                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [pq4_pkg::CFG_DATA_W-1:0] table_lo;
	logic [pq4_pkg::CFG_DATA_W-1:0] table_hi;
	pq4_pkg::sum_t                  partial_sum;
	pq4_pkg::sum_t                  distance_q[$];
	int unsigned                    fail_count;

	function automatic pq4_pkg::value_t table_entry(pq4_pkg::code_t code);
		pq4_pkg::lut_t lut;
		lut = {table_hi, table_lo};
		return lut[code];
	endfunction

	function automatic pq4_pkg::sq_t gap_square(pq4_pkg::value_t query,
			pq4_pkg::value_t entry);
		pq4_pkg::value_t gap;
		gap = (query >= entry) ? query - entry : entry - query;
		return pq4_pkg::sq_t'(gap) * pq4_pkg::sq_t'(gap);
	endfunction

	function automatic pq4_pkg::sum_t add_saturating(pq4_pkg::sum_t acc,
			pq4_pkg::sq_t even_sq, pq4_pkg::sq_t odd_sq);
		logic [pq4_pkg::SUM_W+1:0] total;
		total = (pq4_pkg::SUM_W+2)'(acc) + (pq4_pkg::SUM_W+2)'(even_sq)
			+ (pq4_pkg::SUM_W+2)'(odd_sq);
		return (total > (pq4_pkg::SUM_W+2)'(pq4_pkg::SUM_MAX)) ? pq4_pkg::SUM_MAX
			: total[pq4_pkg::SUM_W-1:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pq4_pkg::sum_t next_sum;
		pq4_pkg::sum_t want;
		if (!arst_n) begin
			table_lo = '0;
			table_hi = '0;
			partial_sum = '0;
			distance_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == pq4_pkg::REG_TABLE_LOW)
					table_lo = cfg_data;
				else if (cfg_index == pq4_pkg::REG_TABLE_HIGH)
					table_hi = cfg_data;
			end
			if (out_valid && out_ready) begin
				if (distance_q.size() == 0) begin
					$error("squared_distance: unexpected result, actual %0d", squared_distance);
					fail_count++;
				end else begin
					want = distance_q.pop_front();
					if (squared_distance !== want) begin
						$error("squared_distance: expected %0d, actual %0d", want,
							squared_distance);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				next_sum = add_saturating(partial_sum,
					gap_square(query_even, table_entry(
						pq4_pkg::code_t'(code_pair & pq4_pkg::NIBBLE_LO_MASK))),
					gap_square(query_odd, table_entry(pq4_pkg::code_t'(
						(code_pair & pq4_pkg::NIBBLE_HI_MASK) >> pq4_pkg::CODE_W))));
				if (vector_end) begin
					distance_q.push_back(next_sum);
					partial_sum = '0;
				end else begin
					partial_sum = next_sum;
				end
			end
		end
		failures <= fail_count;
		pending <= distance_q.size();
	end

endmodule

/* test/tb_pq4_lut_squared_l2_accumulator.sv */
// testbench top for the pq4 squared-l2 accumulator: drives table writes and code
// pair streams with random idling, and gives the verdict from the checker
// depends on pq4_pkg, pq4_lut_squared_l2_accumulator and pq4_l2_distance_checker
module tb_pq4_lut_squared_l2_accumulator;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [pq4_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [pq4_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
	localparam int unsigned MAX_GAP         = 13;
	localparam int unsigned HOLD_CYCLES     = 400;
	localparam int unsigned LONG_PAIRS      = 120;
	localparam int unsigned RANDOM_PHASES   = 7;
	localparam int unsigned PAIRS_PER_PHASE = 200;
	localparam int unsigned DRAIN_LIMIT     = 5000;
	localparam int unsigned TAIL_CYCLES     = 8;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [pq4_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [pq4_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_ready;
	logic [7:0]                     code_pair = '0;
	logic [7:0]                     query_even = '0;
	logic [7:0]                     query_odd = '0;
	logic                           vector_end = 1'b0;
	logic                           out_valid;
	logic                           out_ready = 1'b0;
	logic [31:0]                    squared_distance;
	int unsigned                    failures;
	int unsigned                    pending;
	bit                             quiet = 1'b0;
	bit                             hold_request = 1'b0;

	pq4_lut_squared_l2_accumulator dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.code_pair        (code_pair),
		.query_even       (query_even),
		.query_odd        (query_odd),
		.vector_end       (vector_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.squared_distance (squared_distance)
	);

	pq4_l2_distance_checker distance_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.code_pair        (code_pair),
		.query_even       (query_even),
		.query_odd        (query_odd),
		.vector_end       (vector_end),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.squared_distance (squared_distance),
		.failures         (failures),
		.pending          (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [7:0] pick_query();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic offer_pair(input logic [7:0] codes, input logic [7:0] q_even,
			input logic [7:0] q_odd, input logic last);
		int unsigned gap;
		gap = quiet ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		code_pair <= codes;
		query_even <= q_even;
		query_odd <= q_odd;
		vector_end <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_vector(input int unsigned pairs);
		for (int unsigned k = 1; k <= pairs; k++)
			offer_pair(8'($urandom), pick_query(), pick_query(), k == pairs);
	endtask

	// block is idle once the last vector end has drained
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_table(input logic [63:0] low_word, input logic [63:0] high_word);
		cfg_we <= 1'b1;
		cfg_index <= pq4_pkg::REG_TABLE_LOW;
		cfg_data <= low_word;
		@(posedge clk);
		cfg_index <= pq4_pkg::REG_TABLE_HIGH;
		cfg_data <= high_word;
		@(posedge clk);
		cfg_index <= REG_SPARE_2;
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		cfg_index <= REG_SPARE_3;
		cfg_data <= ~low_word;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : result_sink
		int unsigned stall;
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				stall = quiet ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		int unsigned sent;
		int unsigned pairs;
		int unsigned waited;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// table is all zero out of reset
		offer_pair(8'h00, 8'h00, 8'h00, 1'b1);
		offer_pair(8'hf0, 8'hff, 8'h80, 1'b1);
		settle();

		// ramp table, entry k holds 17k
		load_table(64'h7766554433221100, 64'hffeeddccbbaa9988);
		offer_pair(8'hf0, 8'hff, 8'h00, 1'b1);
		offer_pair(8'h0f, 8'h00, 8'hff, 1'b1);
		offer_pair(8'hf0, 8'h00, 8'hff, 1'b1);
		offer_pair(8'h10, 8'h00, 8'hff, 1'b0);
		offer_pair(8'h32, 8'hff, 8'h00, 1'b0);
		offer_pair(8'h54, 8'h44, 8'h55, 1'b0);
		offer_pair(8'h76, 8'h01, 8'hfe, 1'b0);
		offer_pair(8'h98, 8'h88, 8'h00, 1'b0);
		offer_pair(8'hba, 8'h7f, 8'h80, 1'b0);
		offer_pair(8'hdc, 8'hff, 8'hff, 1'b0);
		offer_pair(8'hfe, 8'h00, 8'h00, 1'b1);
		settle();

		// one long back-to-back vector of widest gaps
		load_table('0, '0);
		quiet = 1'b1;
		for (int unsigned k = 0; k < LONG_PAIRS; k++)
			offer_pair(8'($urandom), 8'hff, 8'hff, k == LONG_PAIRS - 1);
		offer_pair(8'h00, 8'h01, 8'h02, 1'b1);
		settle();

		for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase % 4)
				0: load_table('1, '1);
				1: load_table(64'hff00ff00ff00ff00, 64'h00ff00ff00ff00ff);
				default: load_table({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			quiet = (phase == 3) || (phase == 5);
			// long receiver hold-off while the sender keeps going
			if (phase == 5)
				hold_request = 1'b1;
			sent = 0;
			while (sent < PAIRS_PER_PHASE) begin
				case ($urandom_range(0, 9))
					0: pairs = 1;
					1: pairs = $urandom_range(9, 60);
					default: pairs = $urandom_range(2, 8);
				endcase
				send_vector(pairs);
				sent += pairs;
			end
			settle();
		end

		waited = 0;
		@(posedge clk);
		while (pending != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending != 0)
			$error("%0d distances never arrived", pending);
		if (failures == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
